FILE: rtl/kwih_pkg.sv
// Shared constants, types and the initial word table for the keyed interleaved hash.
`timescale 1ns / 1ps

package kwih_pkg;

	localparam int WORD_CNT = 8;
	localparam int WORD_AW  = $clog2(WORD_CNT);
	localparam int WORD_W   = 32;
	localparam int KEY_W    = 64;
	localparam int POS_W    = 4;
	localparam int BYTE_W   = 8;

	// Configuration register indexes
	localparam logic [0:0] REG_KEY_LOW  = 1'b0;
	localparam logic [0:0] REG_KEY_HIGH = 1'b1;

	// One digest word on its way to the output
	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [WORD_AW-1:0] index;
		logic               last;
	} out_item_t;

	// Initial value of each digest word
	function automatic logic [WORD_W-1:0] init_word(input logic [WORD_AW-1:0] idx);
		logic [WORD_W-1:0] w;
		case (idx)
			3'd0:    w = 32'h6a09e667;
			3'd1:    w = 32'hbb67ae85;
			3'd2:    w = 32'h3c6ef372;
			3'd3:    w = 32'ha54ff53a;
			3'd4:    w = 32'h510e527f;
			3'd5:    w = 32'h9b05688c;
			3'd6:    w = 32'h1f83d9ab;
			3'd7:    w = 32'h5be0cd19;
			default: w = 32'h6a09e667;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/kwih_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kwih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/kwih_ofifo.sv
// Two-entry output queue that decouples digest reads from the receiver's stall.
`timescale 1ns / 1ps

module kwih_ofifo
	import kwih_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	input  logic      pop,
	output out_item_t head_item,
	output logic      not_empty,
	output logic [1:0] count
);

	out_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// Store incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_item = slot_q[rd_ptr_q];
	assign not_empty = (cnt_q != 2'd0);
	assign count     = cnt_q;

endmodule

FILE: rtl/keyed_word_interleaved_hash.sv
// Keyed word-interleaved byte hash: top level with digest RAM, update stage and readout.
//
// Input channel (in_valid / in_stall): one item per cycle when not stalled,
// carrying data_byte, has_byte and last. A byte item updates one digest
// word; an item with has_byte low and last low is taken and does nothing.
// Output channel (out_valid / out_stall): eight items per message, hash_word
// with word_index 0..7, last_word high on word 7.
// Configuration: cfg_we, cfg_index, cfg_data write key_low (index 0) or
// key_high (index 1); a write takes effect from the next accepted byte.
// Throughput: one input item per cycle while a message streams in; the
// eight digest words sit in a one-read, one-write RAM, and each byte is a
// read in the accept cycle and a write in the next, so byte after byte
// never touch the same word in overlapping cycles.
// Readout: after a last item the sequencer goes through ST_WAIT to ST_DRAIN and
// word 0 comes out first, the others following one per cycle unless the receiver
// stalls; the input is stalled while the RAM read port sweeps the eight words out.
// Reset: arst_n clears the keys, the byte position and the per-word valid
// flags; a word that is not valid reads as its initial value, so no clearing
// pass is needed. Message restart clears the flags the same way.
// Receiver stall: a two-entry output queue absorbs stalls; RAM reads for the
// digest pause when the queue has no room, and nothing is lost.
`timescale 1ns / 1ps

module keyed_word_interleaved_hash
	import kwih_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [KEY_W-1:0]    cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                has_byte,
	input  logic                last,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   hash_word,
	output logic [WORD_AW-1:0]  word_index,
	output logic                last_word
);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]          state_q;
	logic [KEY_W-1:0]    key_lo_q;
	logic [KEY_W-1:0]    key_hi_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_CNT-1:0] valid_q;
	logic [WORD_AW-1:0]  cnt_q;

	logic                in_acc;
	logic                byte_acc;
	logic [BYTE_W-1:0]   key_byte;

	// update stage
	logic                byte_s1;
	logic [BYTE_W-1:0]   data_s1;
	logic [BYTE_W-1:0]   key_s1;
	logic [WORD_AW-1:0]  idx_s1;

	// readout stage
	logic                rd_v_s1;
	logic                rd_ok_s1;
	logic [WORD_AW-1:0]  rd_idx_s1;

	logic                ram_rd_en;
	logic [WORD_AW-1:0]  ram_rd_addr;
	logic [WORD_W-1:0]   ram_rd_data;
	logic                ram_wr_en;
	logic [WORD_W-1:0]   ram_wr_data;
	logic [WORD_W-1:0]   cur_word;

	logic                drain_issue;
	logic                drain_done;
	logic [1:0]          occ;
	logic                out_pop;
	logic [1:0]          q_count;
	out_item_t           push_item;
	out_item_t           head_item;

	// Input handshake
	assign in_stall = (state_q != ST_RUN);
	assign in_acc   = in_valid && !in_stall;
	assign byte_acc = in_acc && has_byte;

	// Select key byte for the current position
	always_comb begin
		if (pos_q[POS_W-1]) begin
			key_byte = key_hi_q[{pos_q[WORD_AW-1:0], 3'b000} +: BYTE_W];
		end else begin
			key_byte = key_lo_q[{pos_q[WORD_AW-1:0], 3'b000} +: BYTE_W];
		end
	end

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_lo_q <= cfg_data;
				REG_KEY_HIGH: key_hi_q <= cfg_data;
				default:      key_lo_q <= key_lo_q;
			endcase
		end
	end

	// Readout credit: issue a read only if the queue will have room
	assign out_pop     = out_valid && !out_stall;
	assign occ         = q_count + {1'b0, rd_v_s1};
	assign drain_issue = (state_q == ST_DRAIN) && ((occ < 2'd2) || ((occ == 2'd2) && out_pop));
	assign drain_done  = drain_issue && (cnt_q == WORD_AW'(WORD_CNT - 1));

	// Shared RAM read port
	assign ram_rd_en   = byte_acc || drain_issue;
	assign ram_rd_addr = (state_q == ST_DRAIN) ? cnt_q : pos_q[WORD_AW-1:0];

	// Update: word * 31 + byte, then XOR key byte
	assign cur_word    = valid_q[idx_s1] ? ram_rd_data : init_word(idx_s1);
	assign ram_wr_en   = byte_s1;
	assign ram_wr_data = (((cur_word << 5) - cur_word) + {{(WORD_W-BYTE_W){1'b0}}, data_s1})
		^ {{(WORD_W-BYTE_W){1'b0}}, key_s1};

	kwih_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORD_CNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (idx_s1),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Update stage payload
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			data_s1 <= data_byte;
			key_s1  <= key_byte;
			idx_s1  <= pos_q[WORD_AW-1:0];
		end
		if (drain_issue) begin
			rd_idx_s1 <= cnt_q;
			rd_ok_s1  <= valid_q[cnt_q];
		end
	end

	// Control state: sequencer, position, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			pos_q   <= '0;
			valid_q <= '0;
			cnt_q   <= '0;
			byte_s1 <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			byte_s1 <= byte_acc;
			rd_v_s1 <= drain_issue;
			if (byte_acc) begin
				pos_q <= pos_q + POS_W'(1);
			end
			// restart message once the last word is read
			if (drain_done) begin
				valid_q <= '0;
				pos_q   <= '0;
			end else if (ram_wr_en) begin
				valid_q[idx_s1] <= 1'b1;
			end
			case (state_q)
				ST_RUN: begin
					if (in_acc && last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_DRAIN;
					cnt_q   <= '0;
				end
				ST_DRAIN: begin
					if (drain_issue) begin
						cnt_q <= cnt_q + WORD_AW'(1);
					end
					if (drain_done) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Output queue
	assign push_item.word  = rd_ok_s1 ? ram_rd_data : init_word(rd_idx_s1);
	assign push_item.index = rd_idx_s1;
	assign push_item.last  = (rd_idx_s1 == WORD_AW'(WORD_CNT - 1));

	kwih_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_v_s1),
		.push_item (push_item),
		.pop       (out_pop),
		.head_item (head_item),
		.not_empty (out_valid),
		.count     (q_count)
	);

	assign hash_word  = head_item.word;
	assign word_index = head_item.index;
	assign last_word  = head_item.last;

	// Checks
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && ram_rd_en) |-> (idx_s1 != ram_rd_addr))
		else $error("digest RAM read and write hit the same word");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last) |=> (state_q == ST_WAIT) ##1 (state_q == ST_DRAIN))
		else $error("last item did not start digest readout");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (state_q == ST_RUN) && (valid_q == '0) && (pos_q == '0))
		else $error("message did not restart after readout");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> ((q_count < 2'd2) || out_pop))
		else $error("output queue overflow");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the keyed word-interleaved byte hash.
`timescale 1ns / 1ps

module tb;
	import kwih_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;

	// Digest predictor: its own key, word and position state plus the queue of digest words due
	class digest_scoreboard;
		bit [KEY_W-1:0]  key_lo;
		bit [KEY_W-1:0]  key_hi;
		bit [WORD_W-1:0] words [WORD_CNT];
		bit [POS_W-1:0]  pos;
		out_item_t       due_q [$];
		int              errors;

		function new();
			key_lo = '0;
			key_hi = '0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			words[0] = 32'h6a09e667;
			words[1] = 32'hbb67ae85;
			words[2] = 32'h3c6ef372;
			words[3] = 32'ha54ff53a;
			words[4] = 32'h510e527f;
			words[5] = 32'h9b05688c;
			words[6] = 32'h1f83d9ab;
			words[7] = 32'h5be0cd19;
			pos = '0;
		endfunction

		function void write_key(bit [0:0] idx, bit [KEY_W-1:0] value);
			if (idx == REG_KEY_LOW)
				key_lo = value;
			else if (idx == REG_KEY_HIGH)
				key_hi = value;
		endfunction

		// Absorb one accepted item; queue the digest on a message end
		function void note_item(bit [BYTE_W-1:0] data, bit carries, bit ends);
			bit [KEY_W-1:0]   half;
			bit [BYTE_W-1:0]  kb;
			bit [WORD_AW-1:0] w;
			out_item_t        o;
			if (carries) begin
				half = pos[3] ? key_hi : key_lo;
				kb = half[pos[2:0]*8 +: 8];
				w = pos[2:0];
				words[w] = (words[w] * 32'd31 + {24'd0, data}) ^ {24'd0, kb};
				pos = pos + 1'b1;
			end
			if (ends) begin
				for (int j = 0; j < WORD_CNT; j++) begin
					o.word = words[j];
					o.index = j[WORD_AW-1:0];
					o.last = (j == WORD_CNT - 1);
					due_q.push_back(o);
				end
				restart();
			end
		endfunction

		// Compare one accepted digest word against the oldest one due
		function void check_word(bit [WORD_W-1:0] word, bit [WORD_AW-1:0] idx, bit lw);
			out_item_t o;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d last %0b",
					$time, word, idx, lw);
				errors++;
				return;
			end
			o = due_q.pop_front();
			if (word !== o.word) begin
				$display("%0t: hash_word expected %h actual %h", $time, o.word, word);
				errors++;
			end
			if (idx !== o.index) begin
				$display("%0t: word_index expected %0d actual %0d", $time, o.index, idx);
				errors++;
			end
			if (lw !== o.last) begin
				$display("%0t: last_word expected %0b actual %0b", $time, o.last, lw);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [KEY_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [BYTE_W-1:0]  data_byte;
	logic               has_byte;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic [WORD_W-1:0]  hash_word;
	logic [WORD_AW-1:0] word_index;
	logic               last_word;

	digest_scoreboard sb;
	int cycles = 0;
	int gap_mode;
	int stall_mode;

	keyed_word_interleaved_hash u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_word  (hash_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Check every accepted digest word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(hash_word, word_index, last_word);
	end

	// Stall the output in held stretches, mostly short, a few long
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 25);
					default: out_stall <= ($urandom_range(0, 99) < 45);
				endcase
				hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(6, 20);
			end
		end
	end

	function automatic int next_gap();
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_item(bit [BYTE_W-1:0] data, bit carries, bit ends);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			data_byte <= BYTE_W'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= data;
		has_byte <= carries;
		last <= ends;
		do @(posedge clk); while (in_stall);
		sb.note_item(data, carries, ends);
	endtask

	// Drop valid and wait until every digest word is out and the block is quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(bit [0:0] idx, bit [KEY_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_key(idx, value);
	endtask

	// Messages of random length and content, some idle items mixed in
	task automatic random_messages(int budget);
		int sent;
		int len;
		bit tail_last;
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 40);
			tail_last = (len > 0) && $urandom_range(0, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 8)
					send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
				send_item(BYTE_W'($urandom_range(0, 255)), 1'b1,
					tail_last && (i == len - 1));
			end
			if (!tail_last)
				send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
			sent += len + (tail_last ? 0 : 1);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		last = 1'b0;
		gap_mode = 0;
		stall_mode = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle item, empty message, byte with last, bare end, wrap past 16 bytes
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		for (int i = 0; i < 17; i++) begin
			if (i == 9)
				send_item(8'h5a, 1'b0, 1'b0);
			send_item(i[0] ? 8'h00 : 8'hff, 1'b1, i == 16);
		end
		settle();

		// Random phases, each under its own key and idling pattern
		write_key(REG_KEY_LOW, '1);
		write_key(REG_KEY_HIGH, '1);
		gap_mode = 1;
		stall_mode = 1;
		random_messages(50);
		settle();

		write_key(REG_KEY_LOW, {$urandom, $urandom});
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		gap_mode = 0;
		stall_mode = 0;
		random_messages(50);
		settle();

		write_key(REG_KEY_LOW, 64'haa55aa55aa55aa55);
		write_key(REG_KEY_HIGH, 64'h55aa55aa55aa55aa);
		gap_mode = 1;
		stall_mode = 2;
		random_messages(50);
		settle();

		write_key(REG_KEY_LOW, '0);
		write_key(REG_KEY_HIGH, '1);
		gap_mode = 0;
		stall_mode = 2;
		random_messages(50);
		settle();

		write_key(REG_KEY_LOW, '1);
		write_key(REG_KEY_HIGH, '0);
		gap_mode = 1;
		stall_mode = 0;
		random_messages(50);
		settle();

		write_key(REG_KEY_LOW, {$urandom, $urandom});
		write_key(REG_KEY_HIGH, {$urandom, $urandom});
		gap_mode = 1;
		stall_mode = 1;
		random_messages(50);
		settle();

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/kwih_pkg.sv
rtl/kwih_ram.sv
rtl/kwih_ofifo.sv
rtl/keyed_word_interleaved_hash.sv
tb/tb.sv
